// ===== hdl/csim_pkg.sv =====
// Shared types and constants of the cosine similarity engine.
package csim_pkg;

    localparam int ElemWidth  = 16;
    localparam int DotWidth   = 44;
    localparam int NormWidth  = 43;
    localparam int MagWidth   = 17;
    localparam int WordWidth  = 32;
    localparam int AccWidth   = 128;
    localparam int ProdWidth  = 86;
    localparam int DmagWidth  = 44;
    localparam int RhsWidth   = 88;

    localparam logic [MagWidth-1:0] OUT_ONE = 17'd32768;

    localparam logic [1:0] OP_QC = 2'd0;
    localparam logic [1:0] OP_DD = 2'd1;
    localparam logic [1:0] OP_TP = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       clear_sums;
        logic       init_search;
        logic       acc_clear;
        logic       mul_en;
        logic [1:0] op;
        logic [1:0] pi;
        logic       pj;
        logic       store_p;
        logic       store_r;
        logic       calc_mid;
        logic       calc_odd;
        logic       cmp_step;
        logic       capture;
    } cmd_t;

    typedef struct packed {
        logic zero_norm;
        logic search_done;
    } status_t;

endpackage

// ===== hdl/csim_in_if.sv =====
// Input channel carrying one element pair per transaction.
interface csim_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] query_element;
    logic [15:0] candidate_element;
    logic        last_element;

    modport source (output valid, output query_element, output candidate_element,
                    output last_element, input ready);
    modport sink (input valid, input query_element, input candidate_element,
                  input last_element, output ready);
endinterface

// ===== hdl/csim_out_if.sv =====
// Output channel carrying one similarity result per transaction.
interface csim_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] similarity;
    logic        zero_norm;

    modport source (output valid, output similarity, output zero_norm, input ready);
    modport sink (input valid, input similarity, input zero_norm, output ready);
endinterface

// ===== hdl/csim_dp.sv =====
// Datapath: running sums, shared 32x32 multiplier, accumulator and root search.
module csim_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csim_pkg::cmd_t        cmd,
    input  logic [15:0]           query_element,
    input  logic [15:0]           candidate_element,
    output csim_pkg::status_t     status,
    output logic [15:0]           similarity,
    output logic                  zero_norm
);

    logic [csim_pkg::DotWidth-1:0]  dot_reg, dot_next;
    logic [csim_pkg::NormWidth-1:0] qn_reg, qn_next;
    logic [csim_pkg::NormWidth-1:0] cn_reg, cn_next;
    logic                           neg_reg;
    logic [csim_pkg::DmagWidth-1:0] dmag_reg;
    logic [csim_pkg::ProdWidth-1:0] p_reg;
    logic [csim_pkg::RhsWidth-1:0]  r_reg;
    logic [csim_pkg::MagWidth-1:0]  lo_reg, hi_reg, mid_reg;
    logic [31:0]                    odd2_reg;
    logic [csim_pkg::AccWidth-1:0]  acc_reg;
    logic [63:0]                    prod_reg;
    logic [1:0]                     shift_reg;
    logic                           prod_valid_reg;
    logic [15:0]                    sim_reg;
    logic                           zero_reg;

    logic signed [15:0] q_s, c_s;
    logic signed [31:0] qc_s, qq_s, cc_s;
    logic [44:0]        dot_ext;
    logic [43:0]        qn_ext, cn_ext;
    logic [95:0]        a_vec;
    logic [63:0]        b_vec;
    logic [31:0]        a_word, b_word;
    logic [csim_pkg::MagWidth-1:0] mid_calc, odd_ext;
    logic [15:0]        odd;
    logic [csim_pkg::AccWidth-1:0] rhs_full, prod_shifted;
    logic               mag_ok;
    logic [15:0]        sim_calc;

    assign q_s  = $signed(query_element);
    assign c_s  = $signed(candidate_element);
    assign qc_s = q_s * c_s;
    assign qq_s = q_s * q_s;
    assign cc_s = c_s * c_s;

    always_comb
    begin
        dot_ext = {dot_reg[43], dot_reg} + {{13{qc_s[31]}}, qc_s};
        if (dot_ext[44] != dot_ext[43])
        begin
            dot_next = dot_ext[44] ? {1'b1, 43'd0} : {1'b0, {43{1'b1}}};
        end
        else
        begin
            dot_next = dot_ext[43:0];
        end
        qn_ext  = {1'b0, qn_reg} + {12'd0, qq_s};
        cn_ext  = {1'b0, cn_reg} + {12'd0, cc_s};
        qn_next = qn_ext[43] ? {43{1'b1}} : qn_ext[42:0];
        cn_next = cn_ext[43] ? {43{1'b1}} : cn_ext[42:0];
    end

    always_comb
    begin
        case (cmd.op)
            csim_pkg::OP_QC:
            begin
                a_vec = {53'd0, qn_reg};
                b_vec = {21'd0, cn_reg};
            end
            csim_pkg::OP_DD:
            begin
                a_vec = {52'd0, dmag_reg};
                b_vec = {20'd0, dmag_reg};
            end
            csim_pkg::OP_TP:
            begin
                a_vec = {10'd0, p_reg};
                b_vec = {32'd0, odd2_reg};
            end
            default:
            begin
                a_vec = '0;
                b_vec = '0;
            end
        endcase
        case (cmd.pi)
            2'd0:    a_word = a_vec[31:0];
            2'd1:    a_word = a_vec[63:32];
            2'd2:    a_word = a_vec[95:64];
            default: a_word = '0;
        endcase
        b_word = cmd.pj ? b_vec[63:32] : b_vec[31:0];
    end

    assign prod_shifted = {64'd0, prod_reg} << (7'(shift_reg) * 7'd32);
    assign rhs_full     = {8'd0, r_reg, 32'd0};
    assign mag_ok       = acc_reg <= rhs_full;
    assign mid_calc     = lo_reg + ((hi_reg - lo_reg + 17'd1) >> 1);
    assign odd_ext      = {mid_reg[15:0], 1'b0} - 17'd1;
    assign odd          = odd_ext[15:0];

    always_comb
    begin
        if (neg_reg)
        begin
            sim_calc = 16'(17'd0 - lo_reg);
        end
        else if (lo_reg >= csim_pkg::OUT_ONE)
        begin
            sim_calc = 16'h7FFF;
        end
        else
        begin
            sim_calc = lo_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg        <= '0;
            qn_reg         <= '0;
            cn_reg         <= '0;
            prod_valid_reg <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
        end
        else
        begin
            if (cmd.clear_sums)
            begin
                dot_reg <= '0;
                qn_reg  <= '0;
                cn_reg  <= '0;
            end
            else if (cmd.accept)
            begin
                dot_reg <= dot_next;
                qn_reg  <= qn_next;
                cn_reg  <= cn_next;
            end
            prod_valid_reg <= cmd.mul_en;
            if (cmd.init_search)
            begin
                lo_reg <= '0;
                hi_reg <= csim_pkg::OUT_ONE;
            end
            else if (cmd.cmp_step)
            begin
                if (mag_ok)
                begin
                    lo_reg <= mid_reg;
                end
                else
                begin
                    hi_reg <= mid_reg - 17'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_search)
        begin
            neg_reg  <= dot_reg[43];
            dmag_reg <= dot_reg[43] ? 44'd0 - dot_reg : dot_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg  <= a_word * b_word;
            shift_reg <= cmd.pi + {1'b0, cmd.pj};
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_shifted;
        end
        if (cmd.store_p)
        begin
            p_reg <= acc_reg[csim_pkg::ProdWidth-1:0];
        end
        if (cmd.store_r)
        begin
            r_reg <= acc_reg[csim_pkg::RhsWidth-1:0];
        end
        if (cmd.calc_mid)
        begin
            mid_reg <= mid_calc;
        end
        if (cmd.calc_odd)
        begin
            odd2_reg <= odd * odd;
        end
        if (cmd.capture)
        begin
            sim_reg  <= status.zero_norm ? 16'd0 : sim_calc;
            zero_reg <= status.zero_norm;
        end
    end

    assign status.zero_norm   = (qn_reg == '0) || (cn_reg == '0);
    assign status.search_done = lo_reg == hi_reg;
    assign similarity         = sim_reg;
    assign zero_norm          = zero_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) lo_reg <= hi_reg)
        else $error("Search bounds crossed.");
    assert property (@(posedge clk) disable iff (!rst_n) hi_reg <= csim_pkg::OUT_ONE)
        else $error("Search upper bound exceeds one.");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.calc_mid |=> mid_reg > lo_reg)
        else $error("Probe did not advance past lower bound.");
`endif

endmodule

// ===== hdl/csim_ctrl.sv =====
// Controller: sequences accumulation, products, root search and result hand-off.
module csim_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  csim_pkg::status_t  status,
    output csim_pkg::cmd_t     cmd
);

    localparam logic [3:0] S_ACC      = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_QC       = 4'd2;
    localparam logic [3:0] S_QC_DRAIN = 4'd3;
    localparam logic [3:0] S_QC_STORE = 4'd4;
    localparam logic [3:0] S_DD       = 4'd5;
    localparam logic [3:0] S_DD_DRAIN = 4'd6;
    localparam logic [3:0] S_DD_STORE = 4'd7;
    localparam logic [3:0] S_MID      = 4'd8;
    localparam logic [3:0] S_ODD      = 4'd9;
    localparam logic [3:0] S_TP       = 4'd10;
    localparam logic [3:0] S_TP_DRAIN = 4'd11;
    localparam logic [3:0] S_CMP      = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] pi_reg, pi_next;
    logic       pj_reg, pj_next;
    logic       out_valid_reg, out_valid_next;
    logic       accepted;

    assign in_ready  = state_reg == S_ACC;
    assign accepted  = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        cmd        = '0;
        cmd.op     = csim_pkg::OP_QC;
        cmd.pi     = pi_reg;
        cmd.pj     = pj_reg;
        case (state_reg)
            S_ACC:
            begin
                cmd.accept = accepted;
                if (accepted && in_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.init_search = 1'b1;
                cmd.acc_clear   = 1'b1;
                pi_next         = '0;
                pj_next         = 1'b0;
                state_next      = status.zero_norm ? S_OUT : S_QC;
            end
            S_QC, S_DD:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = (state_reg == S_QC) ? csim_pkg::OP_QC : csim_pkg::OP_DD;
                pj_next    = !pj_reg;
                if (pj_reg)
                begin
                    pi_next = pi_reg + 2'd1;
                end
                if (pj_reg && pi_reg == 2'd1)
                begin
                    pi_next    = '0;
                    state_next = (state_reg == S_QC) ? S_QC_DRAIN : S_DD_DRAIN;
                end
            end
            S_QC_DRAIN:
            begin
                state_next = S_QC_STORE;
            end
            S_QC_STORE:
            begin
                cmd.store_p   = 1'b1;
                cmd.acc_clear = 1'b1;
                state_next    = S_DD;
            end
            S_DD_DRAIN:
            begin
                state_next = S_DD_STORE;
            end
            S_DD_STORE:
            begin
                cmd.store_r = 1'b1;
                state_next  = S_MID;
            end
            S_MID:
            begin
                if (status.search_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.calc_mid = 1'b1;
                    state_next   = S_ODD;
                end
            end
            S_ODD:
            begin
                cmd.calc_odd  = 1'b1;
                cmd.acc_clear = 1'b1;
                pi_next       = '0;
                pj_next       = 1'b0;
                state_next    = S_TP;
            end
            S_TP:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = csim_pkg::OP_TP;
                pi_next    = pi_reg + 2'd1;
                if (pi_reg == 2'd2)
                begin
                    pi_next    = '0;
                    state_next = S_TP_DRAIN;
                end
            end
            S_TP_DRAIN:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = S_MID;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture    = 1'b1;
                    cmd.clear_sums = 1'b1;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            pi_reg        <= '0;
            pj_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pi_reg        <= pi_next;
            pj_reg        <= pj_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("Result overwritten while output stalled.");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.mul_en && !cmd.clear_sums)
        else $error("Element accepted during result computation.");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid_reg && state_reg == S_ACC)
        else $error("Capture did not present a result.");
`endif

endmodule

// ===== hdl/cosine_similarity_engine.sv =====
// Top level of the streaming cosine similarity engine.
// Usage: each input transaction on in_ch carries one signed Q1.15 query
// element, the matching candidate element and a last_element flag. The
// block accumulates the dot product and both squared norms; non-last
// elements are taken one per cycle. On the transaction with last_element
// set, the block stops taking input and computes the result, then issues
// one transaction on out_ch with the Q1.15 similarity and the zero_norm flag.
// A vector with a zero norm skips the products and the search and goes
// straight to the result. Otherwise the block forms two wide products of
// four partials each on a shared 32x32 multiplier, then runs a binary search
// of the quotient magnitude of 15 or 16 steps, each step using the same
// multiplier, then captures the result. Throughput is one element per cycle
// inside a vector; no input is taken while a result is computed or waits.
// Reset clears the sums, the controller and the output valid flag.
// A stalled receiver holds the result in the output register; the next
// vector streams in meanwhile and its result waits until the register frees.
module cosine_similarity_engine (
    input  logic              clk,
    input  logic              rst_n,
    csim_in_if.sink           in_ch,
    csim_out_if.source        out_ch
);

    csim_pkg::cmd_t    cmd;
    csim_pkg::status_t status;
    logic              in_ready;
    logic              out_valid;
    logic [15:0]       similarity;
    logic              zero_norm;

    csim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_element),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    csim_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .query_element     (in_ch.query_element),
        .candidate_element (in_ch.candidate_element),
        .status            (status),
        .similarity        (similarity),
        .zero_norm         (zero_norm)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.similarity = similarity;
    assign out_ch.zero_norm  = zero_norm;

endmodule

// ===== sim/tb.sv =====
// Testbench of the cosine similarity engine: directed and random vector pairs checked against a predictor.
module tb;

    typedef struct packed {
        logic [15:0] query_element;
        logic [15:0] candidate_element;
        logic        last_element;
    } pair_t;

    typedef struct packed {
        logic [15:0] similarity;
        logic        zero_norm;
    } score_t;

    localparam longint LimitCycles = 3000000;

    logic clk;
    logic rst_n;
    csim_in_if in_ch ();
    csim_out_if out_ch ();

    cosine_similarity_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    pair_t       pending_pairs[$];
    int          pair_gaps[$];
    score_t      expected_scores[$];
    logic signed [csim_pkg::DotWidth-1:0] dot_acc;
    logic [csim_pkg::NormWidth-1:0]       query_acc;
    logic [csim_pkg::NormWidth-1:0]       cand_acc;
    int          errors;
    int          scores_seen;
    int          zero_seen;
    int          vectors_sent;
    int          send_wait;
    int          recv_wait;
    longint      cycle_count;
    bit          stimulus_done;
    bit          hold_sender;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic predict_pair(input pair_t p);
        logic signed [47:0]  prod;
        logic signed [47:0]  dsum;
        logic [47:0]         qsum;
        logic [47:0]         csum;
        logic signed [15:0]  qe;
        logic signed [15:0]  ce;
        logic signed [31:0]  qe_w;
        logic signed [31:0]  ce_w;
        logic [63:0]         dmag;
        logic [255:0]        rhs;
        logic [255:0]        lhs;
        logic [63:0]         odd;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         mid;
        score_t              s;
        qe = p.query_element;
        ce = p.candidate_element;
        qe_w = qe;
        ce_w = ce;
        prod = qe * ce;
        dsum = dot_acc + prod;
        if (dsum > 48'sh07FF_FFFF_FFFF)
            dsum = 48'sh07FF_FFFF_FFFF;
        if (dsum < -48'sh0800_0000_0000)
            dsum = -48'sh0800_0000_0000;
        dot_acc = dsum[csim_pkg::DotWidth-1:0];
        qsum = query_acc + 48'(qe_w * qe_w);
        csum = cand_acc + 48'(ce_w * ce_w);
        query_acc = (qsum > 48'h7FF_FFFF_FFFF) ? '1 : qsum[csim_pkg::NormWidth-1:0];
        cand_acc = (csum > 48'h7FF_FFFF_FFFF) ? '1 : csum[csim_pkg::NormWidth-1:0];
        if (!p.last_element)
            return;
        if (query_acc == 0 || cand_acc == 0)
        begin
            s.similarity = 16'd0;
            s.zero_norm = 1'b1;
        end
        else
        begin
            dmag = (dot_acc < 0) ? 64'(-dsum) : 64'(dsum);
            rhs = (256'(dmag) << 16) * (256'(dmag) << 16);
            lo = 0;
            hi = 32768;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                odd = 64'(2 * mid - 1);
                lhs = 256'(odd) * 256'(odd) * 256'(query_acc) * 256'(cand_acc);
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            if (dot_acc < 0)
                s.similarity = 16'(-lo);
            else
                s.similarity = (lo >= 32768) ? 16'h7FFF : 16'(lo);
            s.zero_norm = 1'b0;
        end
        expected_scores.push_back(s);
        dot_acc = '0;
        query_acc = '0;
        cand_acc = '0;
    endtask

    task automatic add_pair(input logic [15:0] q, input logic [15:0] c, input logic l);
        pair_t p;
        p.query_element = q;
        p.candidate_element = c;
        p.last_element = l;
        pending_pairs.push_back(p);
        pair_gaps.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: rand_elem = 16'h8000;
            1: rand_elem = 16'h7FFF;
            2: rand_elem = 16'(int'($urandom_range(0, 64)) - 32);
            default: rand_elem = 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int len;
        int total;
        logic [15:0] q;
        errors = 0;
        scores_seen = 0;
        zero_seen = 0;
        vectors_sent = 0;
        stimulus_done = 1'b0;
        hold_sender = 1'b0;
        dot_acc = '0;
        query_acc = '0;
        cand_acc = '0;
        add_pair(16'h7FFF, 16'h7FFF, 1'b1);
        add_pair(16'h8000, 16'h8000, 1'b1);
        add_pair(16'h8000, 16'h7FFF, 1'b1);
        add_pair(16'h7FFF, 16'h8000, 1'b1);
        add_pair(16'h0000, 16'h1234, 1'b1);
        add_pair(16'h1234, 16'h0000, 1'b1);
        add_pair(16'h0000, 16'h0000, 1'b1);
        add_pair(16'h4000, 16'h0000, 1'b0);
        add_pair(16'h0000, 16'h4000, 1'b1);
        add_pair(16'h0001, 16'hFFFF, 1'b0);
        add_pair(16'h0001, 16'h0001, 1'b1);
        add_pair(16'h3000, 16'h4000, 1'b0);
        add_pair(16'h4000, 16'hD000, 1'b1);
        add_pair(16'h0001, 16'h7FFF, 1'b1);
        add_pair(16'h5555, 16'hAAAA, 1'b1);
        for (int i = 0; i < 300; i++)
            add_pair(16'h8000, 16'h8000, i == 299);
        for (int i = 0; i < 300; i++)
            add_pair(16'h8000, 16'h7FFF, i == 299);
        total = 0;
        while (total < 285)
        begin
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
            for (int i = 0; i < len; i++)
            begin
                q = rand_elem();
                if ($urandom_range(0, 7) == 0)
                    add_pair(q, q, i == len - 1);
                else
                    add_pair(q, rand_elem(), i == len - 1);
            end
            total += len;
        end
        stimulus_done = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.query_element <= '0;
            in_ch.candidate_element <= '0;
            in_ch.last_element <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_pair('{in_ch.query_element, in_ch.candidate_element,
                               in_ch.last_element});
                if (in_ch.last_element)
                    vectors_sent <= vectors_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (hold_sender && expected_scores.size() != 0)
                    in_ch.valid <= 1'b0;
                else if (send_wait > 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_pairs.size() != 0 && pair_gaps[0] > 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_wait <= pair_gaps[0] - 1;
                    pair_gaps[0] = 0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.query_element <= pending_pairs[0].query_element;
                    in_ch.candidate_element <= pending_pairs[0].candidate_element;
                    in_ch.last_element <= pending_pairs[0].last_element;
                    void'(pending_pairs.pop_front());
                    void'(pair_gaps.pop_front());
                end
                else
                    in_ch.valid <= 1'b0;
            end
            hold_sender <= (vectors_sent == 30 || vectors_sent == 31);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        score_t exp_s;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                scores_seen <= scores_seen + 1;
                if (out_ch.zero_norm)
                    zero_seen <= zero_seen + 1;
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected result similarity=%h zero_norm=%b",
                             $time, out_ch.similarity, out_ch.zero_norm);
                    errors = errors + 1;
                end
                else
                begin
                    exp_s = expected_scores.pop_front();
                    if (exp_s.similarity !== out_ch.similarity)
                    begin
                        $display("%0t: similarity expected %h actual %h",
                                 $time, exp_s.similarity, out_ch.similarity);
                        errors = errors + 1;
                    end
                    if (exp_s.zero_norm !== out_ch.zero_norm)
                    begin
                        $display("%0t: zero_norm expected %b actual %b",
                                 $time, exp_s.zero_norm, out_ch.zero_norm);
                        errors = errors + 1;
                    end
                end
            end
            if (recv_wait > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                if ($urandom_range(0, 3) == 0 || vectors_sent < 20)
                    out_ch.ready <= 1'b1;
                else
                begin
                    out_ch.ready <= 1'b0;
                    recv_wait <= $urandom_range(0, 11);
                end
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stimulus_done && pending_pairs.size() == 0 && !in_ch.valid
                 && expected_scores.size() == 0) && cycle_count < LimitCycles)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= LimitCycles)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            repeat (300) @(posedge clk);
            $display("Checked %0d similarity results, %0d of them with a zero norm,",
                     scores_seen, zero_seen);
            $display("over %0d vector pairs including two 300-element full-scale vectors.",
                     vectors_sent);
            if (errors == 0 && expected_scores.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
